### rtl/core/fvcw_pkg.sv
// Shared types, constants, the arctangent table and the color wheel table of the flow color wheel block.
package fvcw_pkg;

  localparam int WHEEL_SIZE = 55;
  localparam int TAB_SIZE   = 24;
  localparam int CNT_W      = 6;
  localparam int CORD_W     = 44;
  localparam int RADIUS_W   = 18;
  localparam int BLEND_W    = 24;

  localparam logic [15:0] LARGEST_RESET = 16'd64;
  localparam logic [RADIUS_W-1:0] RADIUS_ONE = 18'd65536;
  localparam logic [RADIUS_W-1:0] RADIUS_SAT = 18'd131072;
  localparam logic [BLEND_W-1:0] WHITE_Q16 = 24'd16711680;
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef enum logic [1:0] {
    MODE_MEASURE = 2'd0,
    MODE_COLOR   = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_DIV_SET,
    ST_DIV,
    ST_COR_SET,
    ST_COR,
    ST_WHEEL,
    ST_BL_A,
    ST_BL_B,
    ST_BL_C,
    ST_FINISH
  } state_t;

  typedef logic [31:0] atan_tab_t [TAB_SIZE];
  typedef logic [23:0] wheel_tab_t [WHEEL_SIZE];

  localparam atan_tab_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic wheel_tab_t build_wheel();
    wheel_tab_t tab;
    int r;
    int g;
    int b;
    int j;
    for (int k = 0; k < WHEEL_SIZE; k++) begin
      if (k < 15) begin
        r = 255; g = 255 * k / 15; b = 0;
      end else if (k < 21) begin
        j = k - 15; r = 255 - 255 * j / 6; g = 255; b = 0;
      end else if (k < 25) begin
        j = k - 21; r = 0; g = 255; b = 255 * j / 4;
      end else if (k < 36) begin
        j = k - 25; r = 0; g = 255 - 255 * j / 11; b = 255;
      end else if (k < 49) begin
        j = k - 36; r = 255 * j / 13; g = 0; b = 255;
      end else begin
        j = k - 49; r = 255; g = 0; b = 255 - 255 * j / 6;
      end
      tab[k] = {8'(b), 8'(g), 8'(r)};
    end
    return tab;
  endfunction

  localparam wheel_tab_t WHEEL_TAB = build_wheel();

endpackage

### rtl/core/flow_vector_color_wheel.sv
// Top level of the optical flow color wheel block with its shared arithmetic sequencer.
// One item is worked on at a time while in_tready is low. A colored vector goes
// through these steps from acceptance to result: two squaring steps on the shared
// multiplier, one square root bit per cycle, a setup state and 17 restoring divide
// steps for the normalized radius, a setup state and one CORDIC step per cycle for
// the angle, a wheel lookup, nine multiplier steps for the three blended channels
// and a finish state that loads the output register. A measured vector goes through
// the squaring and square root steps only;
// restart, the unused mode and invalid measured vectors leave the block ready on the
// next cycle, and an invalid colored vector goes straight to the finish state and
// gives black. A result that is not taken holds the block busy until the output
// register frees up, and a finished result waits there while the next item is accepted.
module flow_vector_color_wheel #(
  parameter int FLOW_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [15:0]                        cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // flow_x, flow_y
  input  logic [((2*FLOW_BITS+7)/8)*8-1:0]   in_tdata,
  // mode, vector_valid
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red, green, blue
  output logic [23:0]                        out_tdata
);
  import fvcw_pkg::*;

  localparam int FB = FLOW_BITS;
  localparam int SW = 2 * FB;
  localparam int RW = FB + 3;
  localparam int MA = (FB > 18) ? FB : 18;
  localparam int MB = (FB > 24) ? FB : 24;
  localparam int AW = (SW > 25) ? SW : 25;

  state_t state_r, state_nxt;

  logic [15:0]      max_motion_r;
  logic [15:0]      largest_r, largest_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic signed [FB-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [FB-1:0]    ax_r, ax_nxt, ay_r, ay_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [FB-1:0]    root_r, root_nxt;
  logic [17:0]      drem_r, drem_nxt;
  logic [RADIUS_W-1:0] quo_r, quo_nxt;
  logic             sat_r, sat_nxt;
  logic [15:0]      scale_r, scale_nxt;
  logic signed [CORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0]      ph_r, ph_nxt;
  logic [5:0]       k0_r, k0_nxt, k1_r, k1_nxt;
  logic [15:0]      f_r, f_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [23:0]      color_r, color_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic [MA+MB-1:0] mul_p;

  logic             in_fire;
  logic             out_free;
  logic             cnt_last_sqrt, cnt_last_div, cnt_last_cor;
  logic [RW-1:0]    sq_rem, sq_trial;
  logic [FB+15:0]   root_ext;
  logic [15:0]      mag16;
  logic [17:0]      div_diff;
  logic             div_ge;
  logic [4:0]       cidx;
  logic signed [CORD_W-1:0] cdx, cdy;
  logic [32:0]      turn;
  logic [38:0]      fk;
  logic [7:0]       c0, c1;
  logic [BLEND_W-1:0] white_diff;
  logic [25:0]      dim3;
  logic [BLEND_W-1:0] fade_v;
  logic [BLEND_W-1:0] chan_v;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cnt_last_sqrt = (cnt_r == CNT_W'(FB - 1));
  assign cnt_last_div  = (cnt_r == CNT_W'(16));
  assign cnt_last_cor  = (cnt_r == CNT_W'(CORDIC_STEPS - 1));

  assign mul_p = mul_a * mul_b;

  assign sq_rem   = {rem_r[RW-3:0], acc_r[SW-1:SW-2]};
  assign sq_trial = RW'({root_r, 2'b01});
  assign root_ext = (FB + 16)'(root_r);
  assign mag16    = (|root_ext[FB+15:16]) ? 16'hFFFF : root_ext[15:0];

  assign div_ge   = (drem_r >= {2'b00, scale_r});
  assign div_diff = div_ge ? (drem_r - {2'b00, scale_r}) : drem_r;

  assign cidx = cnt_r[4:0];
  assign cdx  = cy_r >>> cidx;
  assign cdy  = cx_r >>> cidx;

  assign turn = (ph_r == 32'd0) ? 33'h1_0000_0000 : {1'b0, ph_r};
  assign fk   = ({6'd0, turn} << 5) + ({6'd0, turn} << 4) + ({6'd0, turn} << 2)
              + ({6'd0, turn} << 1);

  assign c0 = WHEEL_TAB[k0_r][{ch_r, 3'b000} +: 8];
  assign c1 = WHEEL_TAB[k1_r][{ch_r, 3'b000} +: 8];

  assign white_diff = WHITE_Q16 - acc_r[BLEND_W-1:0];
  assign dim3   = {1'b0, acc_r[BLEND_W-1:0], 1'b0} + {2'b00, acc_r[BLEND_W-1:0]};
  assign fade_v = WHITE_Q16 - BLEND_W'(mul_p >> 16);
  assign chan_v = (quo_r <= RADIUS_ONE) ? fade_v : dim3[25:2];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode_t'(in_tuser[1:0]))
            MODE_MEASURE: state_nxt = in_tuser[2] ? ST_SQ_X : ST_IDLE;
            MODE_COLOR:   state_nxt = in_tuser[2] ? ST_SQ_X : ST_FINISH;
            MODE_RESTART: state_nxt = ST_IDLE;
            MODE_UNUSED:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQ_X:    state_nxt = ST_SQ_Y;
      ST_SQ_Y:    state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_last_sqrt) begin
          state_nxt = (mode_r == MODE_MEASURE) ? ST_IDLE : ST_DIV_SET;
        end
      end
      ST_DIV_SET: state_nxt = ST_DIV;
      ST_DIV:     state_nxt = cnt_last_div ? ST_COR_SET : ST_DIV;
      ST_COR_SET: state_nxt = ST_COR;
      ST_COR:     state_nxt = cnt_last_cor ? ST_WHEEL : ST_COR;
      ST_WHEEL:   state_nxt = ST_BL_A;
      ST_BL_A:    state_nxt = ST_BL_B;
      ST_BL_B:    state_nxt = ST_BL_C;
      ST_BL_C:    state_nxt = (ch_r == 2'd2) ? ST_FINISH : ST_BL_A;
      ST_FINISH:  state_nxt = out_free ? ST_IDLE : ST_FINISH;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    largest_nxt   = largest_r;
    mode_nxt      = mode_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    scale_nxt     = scale_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ph_nxt        = ph_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    f_nxt         = f_r;
    ch_nxt        = ch_r;
    color_nxt     = color_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt  = in_tuser[1:0];
          fx_nxt    = in_tdata[FB-1:0];
          fy_nxt    = in_tdata[2*FB-1:FB];
          ax_nxt    = in_tdata[FB-1] ? (FB'(0) - in_tdata[FB-1:0]) : in_tdata[FB-1:0];
          ay_nxt    = in_tdata[2*FB-1] ? (FB'(0) - in_tdata[2*FB-1:FB])
                                       : in_tdata[2*FB-1:FB];
          color_nxt = '0;
          if (in_tuser[1:0] == MODE_RESTART) begin
            largest_nxt = LARGEST_RESET;
          end
        end
      end
      ST_SQ_X: begin
        mul_a   = MA'(ax_r);
        mul_b   = MB'(ax_r);
        acc_nxt = AW'(mul_p);
      end
      ST_SQ_Y: begin
        mul_a    = MA'(ay_r);
        mul_b    = MB'(ay_r);
        acc_nxt  = acc_r + AW'(mul_p);
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
      end
      ST_SQRT: begin
        acc_nxt = acc_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (sq_rem >= sq_trial) begin
          rem_nxt  = sq_rem - sq_trial;
          root_nxt = {root_r[FB-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_rem;
          root_nxt = {root_r[FB-2:0], 1'b0};
        end
      end
      ST_DIV_SET: begin
        if (mode_r == MODE_MEASURE) begin
          largest_nxt = largest_r;
        end
        if (max_motion_r != 16'd0) begin
          scale_nxt = max_motion_r;
        end else if (largest_r != 16'd0) begin
          scale_nxt = largest_r;
        end else begin
          scale_nxt = 16'd1;
        end
        drem_nxt = {2'b00, mag16};
        quo_nxt  = '0;
        cnt_nxt  = '0;
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          sat_nxt = ({1'b0, mag16} >= {scale_r, 1'b0});
        end
        quo_nxt  = {quo_r[RADIUS_W-2:0], div_ge};
        drem_nxt = {div_diff[16:0], 1'b0};
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_COR_SET: begin
        if (sat_r) begin
          quo_nxt = RADIUS_SAT;
        end
        cnt_nxt = '0;
        if (fx_r[FB-1]) begin
          cx_nxt = -(CORD_W'(fx_r) <<< (40 - FB));
          cy_nxt = -(CORD_W'(fy_r) <<< (40 - FB));
          ph_nxt = 32'h8000_0000;
        end else begin
          cx_nxt = CORD_W'(fx_r) <<< (40 - FB);
          cy_nxt = CORD_W'(fy_r) <<< (40 - FB);
          ph_nxt = 32'd0;
        end
      end
      ST_COR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (!cy_r[CORD_W-1]) begin
          cx_nxt = cx_r + cdx;
          cy_nxt = cy_r - cdy;
          ph_nxt = ph_r + ATAN_TURNS[cidx];
        end else begin
          cx_nxt = cx_r - cdx;
          cy_nxt = cy_r + cdy;
          ph_nxt = ph_r - ATAN_TURNS[cidx];
        end
      end
      ST_WHEEL: begin
        k0_nxt = (fk[38:32] > 7'(WHEEL_SIZE - 1)) ? 6'(WHEEL_SIZE - 1) : fk[37:32];
        k1_nxt = (fk[38:32] >= 7'(WHEEL_SIZE - 1)) ? 6'd0 : (fk[37:32] + 6'd1);
        f_nxt  = fk[31:16];
        ch_nxt = '0;
      end
      ST_BL_A: begin
        mul_a   = MA'(FRAC_ONE - {1'b0, f_r});
        mul_b   = MB'(c0);
        acc_nxt = AW'(mul_p);
      end
      ST_BL_B: begin
        mul_a   = MA'(f_r);
        mul_b   = MB'(c1);
        acc_nxt = acc_r + AW'(mul_p);
      end
      ST_BL_C: begin
        mul_a  = MA'(quo_r);
        mul_b  = MB'(white_diff);
        ch_nxt = ch_r + 2'd1;
        color_nxt[{ch_r, 3'b000} +: 8] = chan_v[23:16];
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = color_r;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
    if (state_r == ST_SQRT && cnt_last_sqrt && mode_r == MODE_MEASURE) begin
      if (sq_rem >= sq_trial) begin
        largest_nxt = largest_r;
      end
    end
  end

  logic [FB-1:0] root_final;
  logic [FB+15:0] root_final_ext;
  logic [15:0]    mag_final;

  assign root_final     = {root_r[FB-2:0], (sq_rem >= sq_trial)};
  assign root_final_ext = (FB + 16)'(root_final);
  assign mag_final      = (|root_final_ext[FB+15:16]) ? 16'hFFFF : root_final_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_motion_r <= '0;
      largest_r    <= LARGEST_RESET;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      ch_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      if (cfg_wr_en) begin
        max_motion_r <= cfg_wr_data;
      end
      if (state_r == ST_SQRT && cnt_last_sqrt && mode_r == MODE_MEASURE
          && mag_final > largest_r) begin
        largest_r <= mag_final;
      end else begin
        largest_r <= largest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    drem_r     <= drem_nxt;
    quo_r      <= quo_nxt;
    sat_r      <= sat_nxt;
    scale_r    <= scale_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ph_r       <= ph_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    f_r        <= f_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/core/fvcw_checker.sv
// Port-level checker of the flow color wheel block and its bind to the top level.
module fvcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import fvcw_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_color_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[1:0] == MODE_COLOR) |=> !in_tready)
    else $error("color item accepted without the block going busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("item appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("stalled item changed");

endmodule

bind flow_vector_color_wheel fvcw_checker u_fvcw_checker (.*);
